>>> hw/rtl/url_percent_and_entity_decoder_unit_defines.svh
// Assertion macros used by the checker file of the decoder.
`ifndef URL_PERCENT_AND_ENTITY_DECODER_UNIT_DEFINES_SVH
`define URL_PERCENT_AND_ENTITY_DECODER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define UPDEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UPDEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset was seen.
`define UPDEC_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/updec_pkg.sv
package updec_pkg;

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SOH   = 8'h01;
   localparam logic [7:0] CTRL_LIMIT = 8'd32;

   localparam int FRONT_SLOTS = 3;
   localparam int FRONT_IDX_W = 2;
   localparam int BACK_SLOTS  = 6;
   localparam int BACK_IDX_W  = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;
   localparam int HELD_DEPTH  = 4;
   localparam int NUM_ENT     = 5;
   localparam int ENT_MAX     = 5;

   typedef logic [7:0] char_byte_type;

   typedef struct packed {
      char_byte_type data;
      logic          last;
   } char_type;

   localparam logic [0:NUM_ENT-1][0:ENT_MAX-1][7:0] ENT_NAME =
      {"apos;", "amp;", 8'h00, "gt;", 16'h0000, "lt;", 16'h0000, "quot;"};
   localparam logic [0:NUM_ENT-1][2:0] ENT_LEN = {3'd5, 3'd4, 3'd3, 3'd3, 3'd5};
   localparam logic [0:NUM_ENT-1][7:0] ENT_REP = {8'h27, CHAR_AMP, 8'h3E, 8'h3C, 8'h22};

endpackage

>>> hw/rtl/url_percent_and_entity_decoder_unit.sv
// Decodes the value part of a URL query string, one byte per word.
// The request channel (req_valid, req_ready, req_byte, req_last) takes one
// encoded byte per word; req_last marks the final byte of a string.
// The response channel (rsp_valid, rsp_ready, rsp_byte, rsp_last) gives the
// decoded bytes in order; rsp_last marks the final decoded byte of a string.
// Percent escapes and plus signs are decoded in the front part, which may
// hold up to three bytes for a word that breaks or flushes an escape.
// A four-entry queue feeds the back part, which replaces HTML entities and
// gives one decoded byte per cycle from its output register while the
// receiver is ready. The first result of a word passes through the front
// slots, the queue and the output register. Plain text moves at one word
// per cycle when nothing stalls; a word can release up to six bytes.
// When the receiver stalls, the output register holds its byte, the queue
// fills and then req_ready drops; nothing is lost.
// Reset clears all pending escapes, held entities, the queue and the output.
module url_percent_and_entity_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic       rsp_last
);
   import updec_pkg::*;

   logic     fq_valid, fq_ready;
   char_type fq_char;
   logic     qb_valid, qb_ready;
   char_type qb_char;

   updec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_byte   (req_byte),
      .req_last   (req_last),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_char  (fq_char)
   );

   updec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_char  (fq_char),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_char   (qb_char)
   );

   updec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (qb_valid),
      .pop_ready (qb_ready),
      .pop_char  (qb_char),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

endmodule

>>> hw/rtl/updec_front.sv
module updec_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte,
   input  logic                req_last,
   output logic                push_valid,
   input  logic                push_ready,
   output updec_pkg::char_type push_char
);
   import updec_pkg::*;

   logic [1:0]          esc_cnt_ff, esc_cnt_in;
   char_byte_type       esc_digit_ff, esc_digit_in;
   char_byte_type       slot_ff [FRONT_SLOTS];
   char_byte_type       slot_in [FRONT_SLOTS];
   logic [1:0]          fill_ff, fill_in;
   logic                list_last_ff, list_last_in;

   char_byte_type       lst [FRONT_SLOTS];
   logic [1:0]          lst_n;
   logic                plain_go;
   logic [4:0]          hi_val, lo_val;
   char_byte_type       decoded;
   logic                accept, push_fire;

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         return 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         return 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         return 5'(c - 8'h37);
      end
      return 5'd16;
   endfunction

   assign push_valid = (fill_ff != 2'd0);
   assign push_char  = '{data: slot_ff[0], last: list_last_ff && (fill_ff == 2'd1)};
   assign push_fire  = push_valid && push_ready;
   assign req_ready  = (fill_ff == 2'd0) || ((fill_ff == 2'd1) && push_ready);
   assign accept     = req_valid && req_ready;

   always_comb begin
      hi_val  = hex_val(esc_digit_ff);
      lo_val  = hex_val(req_byte);
      decoded = {hi_val[3:0], lo_val[3:0]};
      if (decoded != CHAR_SOH && decoded < CTRL_LIMIT) begin
         decoded = CHAR_SPACE;
      end
      for (int i = 0; i < FRONT_SLOTS; i++) begin
         lst[i] = req_byte;
      end
      lst_n        = 2'd0;
      plain_go     = 1'b0;
      esc_cnt_in   = 2'd0;
      esc_digit_in = esc_digit_ff;
      unique case (esc_cnt_ff)
         2'd1: begin
            if (!lo_val[4]) begin
               esc_cnt_in   = 2'd2;
               esc_digit_in = req_byte;
            end else begin
               lst[0]   = CHAR_PCT;
               lst_n    = 2'd1;
               plain_go = 1'b1;
            end
         end
         2'd2: begin
            if (!lo_val[4]) begin
               lst[0] = decoded;
               lst_n  = 2'd1;
            end else begin
               lst[0]   = CHAR_PCT;
               lst[1]   = esc_digit_ff;
               lst_n    = 2'd2;
               plain_go = 1'b1;
            end
         end
         default: begin
            plain_go = 1'b1;
         end
      endcase
      if (plain_go) begin
         priority if (req_byte == CHAR_PLUS) begin
            lst[lst_n] = CHAR_SPACE;
            lst_n      = lst_n + 2'd1;
         end else if (req_byte == CHAR_PCT) begin
            esc_cnt_in = 2'd1;
         end else begin
            lst[lst_n] = req_byte;
            lst_n      = lst_n + 2'd1;
         end
      end
      if (req_last) begin
         if (esc_cnt_in != 2'd0) begin
            lst[lst_n] = CHAR_PCT;
            lst_n      = lst_n + 2'd1;
         end
         if (esc_cnt_in == 2'd2) begin
            lst[lst_n] = esc_digit_in;
            lst_n      = lst_n + 2'd1;
         end
         esc_cnt_in = 2'd0;
      end

      fill_in      = fill_ff;
      list_last_in = list_last_ff;
      for (int i = 0; i < FRONT_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (accept) begin
         slot_in      = lst;
         fill_in      = lst_n;
         list_last_in = req_last;
      end else if (push_fire) begin
         for (int i = 0; i < FRONT_SLOTS - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
         fill_in = fill_ff - 2'd1;
      end
      if (!accept) begin
         esc_cnt_in   = esc_cnt_ff;
         esc_digit_in = esc_digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_cnt_ff <= 2'd0;
         fill_ff    <= 2'd0;
      end else begin
         esc_cnt_ff <= esc_cnt_in;
         fill_ff    <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      esc_digit_ff <= esc_digit_in;
      slot_ff      <= slot_in;
      list_last_ff <= list_last_in;
   end

endmodule

>>> hw/rtl/updec_queue.sv
module updec_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  updec_pkg::char_type push_char,
   output logic                pop_valid,
   input  logic                pop_ready,
   output updec_pkg::char_type pop_char
);
   import updec_pkg::*;

   char_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push_fire, pop_fire;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_char   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push_fire) - QUEUE_CNT_W'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_char;
      end
   end

endmodule

>>> hw/rtl/updec_back.sv
module updec_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  updec_pkg::char_type pop_char,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_byte,
   output logic                rsp_last
);
   import updec_pkg::*;

   logic [2:0]              ent_cnt_ff, ent_cnt_in;
   char_byte_type           held_ff [HELD_DEPTH];
   char_byte_type           held_in [HELD_DEPTH];
   char_byte_type           out_ff [BACK_SLOTS];
   char_byte_type           out_in [BACK_SLOTS];
   logic [BACK_IDX_W-1:0]   out_fill_ff, out_fill_in;
   logic                    out_last_ff, out_last_in;

   char_byte_type           c;
   char_byte_type           cand [ENT_MAX];
   logic [2:0]              n_held, len, m_held, cnt_n;
   logic                    full, partial;
   char_byte_type           rep;
   char_byte_type           lst [BACK_SLOTS];
   logic [BACK_IDX_W-1:0]   lst_n;
   char_byte_type           held_n [HELD_DEPTH];
   logic                    take, rsp_fire;

   function automatic logic [2:0] held_of(input logic [2:0] cnt);
      if (cnt == 3'd0) begin
         return 3'd0;
      end else if (cnt > 3'd5) begin
         return 3'd4;
      end
      return cnt - 3'd1;
   endfunction

   assign rsp_valid = (out_fill_ff != '0);
   assign rsp_byte  = out_ff[0];
   assign rsp_last  = out_last_ff && (out_fill_ff == BACK_IDX_W'(1));
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign pop_ready = (out_fill_ff == '0) || ((out_fill_ff == BACK_IDX_W'(1)) && rsp_ready);
   assign take      = pop_valid && pop_ready;
   assign c         = pop_char.data;

   always_comb begin
      logic ok;
      n_held = held_of(ent_cnt_ff);
      len    = n_held + 3'd1;
      for (int i = 0; i < HELD_DEPTH; i++) begin
         cand[i] = (3'(i) < n_held) ? held_ff[i] : c;
      end
      cand[ENT_MAX-1] = c;
      full    = 1'b0;
      partial = 1'b0;
      rep     = c;
      for (int e = 0; e < NUM_ENT; e++) begin
         ok = (len <= ENT_LEN[e]);
         for (int i = 0; i < ENT_MAX; i++) begin
            if (3'(i) < len && cand[i] != ENT_NAME[e][i]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            if (len == ENT_LEN[e]) begin
               full = 1'b1;
               rep  = ENT_REP[e];
            end else begin
               partial = 1'b1;
            end
         end
      end

      for (int i = 0; i < BACK_SLOTS; i++) begin
         lst[i] = c;
      end
      lst_n  = '0;
      cnt_n  = 3'd0;
      held_n = held_ff;
      priority if (ent_cnt_ff == 3'd0) begin
         if (c == CHAR_AMP) begin
            cnt_n = 3'd1;
         end else begin
            lst[lst_n] = c;
            lst_n      = lst_n + 1'b1;
         end
      end else if (full) begin
         lst[lst_n] = rep;
         lst_n      = lst_n + 1'b1;
      end else if (partial && n_held < 3'd4) begin
         held_n[n_held[1:0]] = c;
         cnt_n               = n_held + 3'd2;
      end else begin
         lst[lst_n] = CHAR_AMP;
         lst_n      = lst_n + 1'b1;
         for (int i = 0; i < HELD_DEPTH; i++) begin
            if (3'(i) < n_held) begin
               lst[lst_n] = held_ff[i];
               lst_n      = lst_n + 1'b1;
            end
         end
         if (c == CHAR_AMP) begin
            cnt_n = 3'd1;
         end else begin
            lst[lst_n] = c;
            lst_n      = lst_n + 1'b1;
         end
      end
      m_held = held_of(cnt_n);
      if (pop_char.last) begin
         if (cnt_n != 3'd0) begin
            lst[lst_n] = CHAR_AMP;
            lst_n      = lst_n + 1'b1;
            for (int i = 0; i < HELD_DEPTH; i++) begin
               if (3'(i) < m_held) begin
                  lst[lst_n] = held_n[i];
                  lst_n      = lst_n + 1'b1;
               end
            end
         end
         cnt_n = 3'd0;
      end

      ent_cnt_in  = ent_cnt_ff;
      held_in     = held_ff;
      out_in      = out_ff;
      out_fill_in = out_fill_ff;
      out_last_in = out_last_ff;
      if (take) begin
         ent_cnt_in  = cnt_n;
         held_in     = held_n;
         out_in      = lst;
         out_fill_in = lst_n;
         out_last_in = pop_char.last;
      end else if (rsp_fire) begin
         for (int i = 0; i < BACK_SLOTS - 1; i++) begin
            out_in[i] = out_ff[i + 1];
         end
         out_fill_in = out_fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_cnt_ff  <= 3'd0;
         out_fill_ff <= '0;
      end else begin
         ent_cnt_ff  <= ent_cnt_in;
         out_fill_ff <= out_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

endmodule

>>> hw/rtl/updec_checker.sv
`include "url_percent_and_entity_decoder_unit_defines.svh"

module updec_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_last
);

   logic [3:0] open_ff, open_in;
   logic       last_in_fire, last_out_fire;

   assign last_in_fire  = req_valid && req_ready && req_last;
   assign last_out_fire = rsp_valid && rsp_ready && rsp_last;

   always_comb begin
      open_in = open_ff + 4'(last_in_fire) - 4'(last_out_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 4'd0;
      end else begin
         open_ff <= open_in;
      end
   end

   // A stalled result word keeps its contents.
   `UPDEC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte) && $stable(rsp_last), "result word changed while stalled")
   // Every closing result word belongs to a string whose last byte came in.
   `UPDEC_ASSERT_NOW(a_last_owed, last_out_fire, open_ff != 4'd0, "string closed that was never ended")
   // The pipeline cannot hold more unfinished strings than it has places.
   `UPDEC_ASSERT_NOW(a_open_bound, req_valid || !req_valid, open_ff < 4'd8, "too many strings in flight")
   `UPDEC_ASSERT_RESET(a_reset_idle, !rsp_valid, "result valid right after reset")

endmodule

bind url_percent_and_entity_decoder_unit updec_checker u_updec_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_last  (req_last),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_byte  (rsp_byte),
   .rsp_last  (rsp_last)
);
